FILE: design/ih_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Interval histogram package
// Shared constants, operation codes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package ih_pkg;

    localparam int NUM_BINS_DEF = 128;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_BOUND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_BOUND = 2'd1;

    localparam logic [31:0] LOWER_BOUND_RST = 32'd500000;
    localparam logic [31:0] UPPER_BOUND_RST = 32'd7000000;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // Gaps of six seconds or more always exceed the 32-bit nanosecond range.
    localparam logic signed [32:0] MAX_NEAR_SECONDS = 33'sd5;
    localparam logic signed [33:0] NS_PER_SECOND    = 34'sd1000000000;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GAP_DIFF,
        ST_GAP_SUM,
        ST_GAP_MAG,
        ST_SCALE,
        ST_DIVIDE,
        ST_MEM_RD,
        ST_MEM_UPD
    } state_t;

endpackage : ih_pkg
`default_nettype wire

FILE: design/interval_histogram_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Interval histogram core
// Bins the gap between successive arrival timestamps into a histogram of
// saturating 32-bit counters and returns one bin count on request.
// ----------------------------------------------------------------------------
// After reset the block sweeps the counter memory to zero, one bin per cycle,
// so busy stays high through the sweep before the first command is taken.
// A command is taken when start is high and busy is low; its result appears
// on the result ports for one cycle with done high and must be captured then.
// The first timestamp after reset only primes the reference time and gives
// its result on the cycle after the transfer, without raising busy. A bin
// read keeps busy high through the memory read and the registered data.
// A timestamp record whose gap falls inside the range keeps busy high while
// the gap-difference, gap-sum and gap-magnitude states form the saturated gap,
// the scale state scales it, a shared restoring subtractor then produces one
// quotient bit per cycle, and the memory read and update states read and write
// back the counter through the single memory port. A gap outside the range,
// or any gap when the range is empty, skips the division.
// Configuration writes are always accepted and take effect at once.
module interval_histogram_core
    import ih_pkg::*;
#(
    parameter int NUM_BINS = NUM_BINS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 op,
    input  wire logic [31:0]          stamp_seconds,
    input  wire logic [29:0]          stamp_nanoseconds,
    input  wire logic [6:0]           read_bin,
    output logic                      done,
    output logic [6:0]                bin_index,
    output logic [31:0]               bin_count,
    output logic [31:0]               interval_ns,
    output logic                      first_sample,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);

    localparam int BIN_W = $clog2(NUM_BINS);
    localparam int NUM_W = 32 + BIN_W;
    localparam int CNT_W = $clog2(BIN_W + 1);

    state_t state_reg, state_next;

    logic                    have_prev_reg, have_prev_next;
    logic                    done_reg, done_next;
    logic [31:0]             lower_reg, lower_next;
    logic [31:0]             upper_reg, upper_next;
    logic [BIN_W-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0]        div_cnt_reg, div_cnt_next;

    logic                    op_reg, op_next;
    logic [31:0]             sec_reg, sec_next;
    logic [29:0]             nsec_reg, nsec_next;
    logic [31:0]             prev_sec_reg, prev_sec_next;
    logic [29:0]             prev_nsec_reg, prev_nsec_next;
    logic [6:0]              rb_reg, rb_next;
    logic                    in_range_reg, in_range_next;
    logic signed [32:0]      ds_reg, ds_next;
    logic signed [30:0]      dn_reg, dn_next;
    logic signed [33:0]      total_reg, total_next;
    logic                    sat_reg, sat_next;
    logic [31:0]             gap_reg, gap_next;
    logic [NUM_W-1:0]        rem_reg, rem_next;
    logic [NUM_W-1:0]        dsr_reg, dsr_next;
    logic [BIN_W-1:0]        quo_reg, quo_next;
    logic [BIN_W-1:0]        bin_reg, bin_next;

    logic [6:0]              bin_index_reg, bin_index_next;
    logic [31:0]             bin_count_reg, bin_count_next;
    logic [31:0]             interval_reg, interval_next;
    logic                    first_reg, first_next;

    logic [31:0]             count_mem [NUM_BINS];
    logic [31:0]             mem_rdata_reg;
    logic                    mem_we;
    logic [BIN_W-1:0]        mem_addr;
    logic [31:0]             mem_wdata;

    logic signed [33:0]      ds_ext;
    logic signed [33:0]      dn_ext;
    logic [33:0]             mag;
    logic [31:0]             span;
    logic [NUM_W-1:0]        trial;
    logic                    trial_ok;
    logic [31:0]             count_inc;

    assign ds_ext    = 34'(signed'(ds_reg[3:0]));
    assign dn_ext    = 34'(dn_reg);
    assign mag       = total_reg[33] ? 34'(-total_reg) : 34'(total_reg);
    assign span      = upper_reg - lower_reg;
    assign trial     = rem_reg - dsr_reg;
    assign trial_ok  = (rem_reg >= dsr_reg);
    assign count_inc = (mem_rdata_reg == 32'hFFFF_FFFF) ? mem_rdata_reg
                                                         : mem_rdata_reg + 32'd1;

    always_comb
    begin
        state_next     = state_reg;
        have_prev_next = have_prev_reg;
        done_next      = 1'b0;
        lower_next     = lower_reg;
        upper_next     = upper_reg;
        clr_cnt_next   = clr_cnt_reg;
        div_cnt_next   = div_cnt_reg;
        op_next        = op_reg;
        sec_next       = sec_reg;
        nsec_next      = nsec_reg;
        prev_sec_next  = prev_sec_reg;
        prev_nsec_next = prev_nsec_reg;
        rb_next        = rb_reg;
        in_range_next  = in_range_reg;
        ds_next        = ds_reg;
        dn_next        = dn_reg;
        total_next     = total_reg;
        sat_next       = sat_reg;
        gap_next       = gap_reg;
        rem_next       = rem_reg;
        dsr_next       = dsr_reg;
        quo_next       = quo_reg;
        bin_next       = bin_reg;
        bin_index_next = bin_index_reg;
        bin_count_next = bin_count_reg;
        interval_next  = interval_reg;
        first_next     = first_reg;
        mem_we         = 1'b0;
        mem_addr       = bin_reg;
        mem_wdata      = count_inc;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LOWER_BOUND: lower_next = cfg_data;
                CFG_UPPER_BOUND: upper_next = cfg_data;
                default:         ;
            endcase
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_addr     = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == BIN_W'(NUM_BINS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    op_next       = op;
                    sec_next      = stamp_seconds;
                    nsec_next     = stamp_nanoseconds;
                    rb_next       = read_bin;
                    in_range_next = (32'(read_bin) < 32'(NUM_BINS));
                    if (op == OP_READ)
                    begin
                        bin_next   = BIN_W'(32'(read_bin));
                        state_next = ST_MEM_RD;
                    end
                    else if (!have_prev_reg)
                    begin
                        // The first timestamp only sets the reference time.
                        prev_sec_next  = stamp_seconds;
                        prev_nsec_next = stamp_nanoseconds;
                        have_prev_next = 1'b1;
                        bin_index_next = '0;
                        bin_count_next = '0;
                        interval_next  = '0;
                        first_next     = 1'b1;
                        done_next      = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_GAP_DIFF;
                    end
                end
            end

            ST_GAP_DIFF:
            begin
                ds_next        = signed'({1'b0, sec_reg}) - signed'({1'b0, prev_sec_reg});
                dn_next        = signed'({1'b0, nsec_reg}) - signed'({1'b0, prev_nsec_reg});
                prev_sec_next  = sec_reg;
                prev_nsec_next = nsec_reg;
                state_next     = ST_GAP_SUM;
            end

            ST_GAP_SUM:
            begin
                sat_next   = (ds_reg > MAX_NEAR_SECONDS) || (ds_reg < -MAX_NEAR_SECONDS);
                total_next = ds_ext * NS_PER_SECOND + dn_ext;
                state_next = ST_GAP_MAG;
            end

            ST_GAP_MAG:
            begin
                gap_next   = (sat_reg || (mag[33:32] != 2'b00)) ? 32'hFFFF_FFFF : mag[31:0];
                state_next = ST_SCALE;
            end

            ST_SCALE:
            begin
                // Below the range or with an empty range the gap lands in the
                // first bin; at or above the top it lands in the last one.
                if ((upper_reg <= lower_reg) || (gap_reg < lower_reg))
                begin
                    bin_next   = '0;
                    state_next = ST_MEM_RD;
                end
                else if (gap_reg >= upper_reg)
                begin
                    bin_next   = BIN_W'(NUM_BINS - 1);
                    state_next = ST_MEM_RD;
                end
                else
                begin
                    rem_next     = NUM_W'(gap_reg - lower_reg) * NUM_W'(NUM_BINS);
                    dsr_next     = NUM_W'(span) << (BIN_W - 1);
                    quo_next     = '0;
                    div_cnt_next = CNT_W'(BIN_W - 1);
                    state_next   = ST_DIVIDE;
                end
            end

            ST_DIVIDE:
            begin
                // The quotient is known to be below NUM_BINS, so BIN_W
                // restoring steps give it exactly.
                if (trial_ok)
                begin
                    rem_next = trial;
                end
                quo_next = (quo_reg << 1) | BIN_W'(trial_ok);
                dsr_next = dsr_reg >> 1;
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == '0)
                begin
                    bin_next   = (quo_reg << 1) | BIN_W'(trial_ok);
                    state_next = ST_MEM_RD;
                end
            end

            ST_MEM_RD:
            begin
                state_next = ST_MEM_UPD;
            end

            ST_MEM_UPD:
            begin
                first_next = 1'b0;
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if (op_reg == OP_READ)
                begin
                    bin_index_next = rb_reg;
                    bin_count_next = in_range_reg ? mem_rdata_reg : '0;
                    interval_next  = '0;
                end
                else
                begin
                    mem_we         = 1'b1;
                    bin_index_next = 7'(bin_reg);
                    bin_count_next = count_inc;
                    interval_next  = gap_reg;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            have_prev_reg <= 1'b0;
            done_reg      <= 1'b0;
            lower_reg     <= LOWER_BOUND_RST;
            upper_reg     <= UPPER_BOUND_RST;
            clr_cnt_reg   <= '0;
            div_cnt_reg   <= '0;
            prev_sec_reg  <= '0;
            prev_nsec_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            have_prev_reg <= have_prev_next;
            done_reg      <= done_next;
            lower_reg     <= lower_next;
            upper_reg     <= upper_next;
            clr_cnt_reg   <= clr_cnt_next;
            div_cnt_reg   <= div_cnt_next;
            prev_sec_reg  <= prev_sec_next;
            prev_nsec_reg <= prev_nsec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        sec_reg       <= sec_next;
        nsec_reg      <= nsec_next;
        rb_reg        <= rb_next;
        in_range_reg  <= in_range_next;
        ds_reg        <= ds_next;
        dn_reg        <= dn_next;
        total_reg     <= total_next;
        sat_reg       <= sat_next;
        gap_reg       <= gap_next;
        rem_reg       <= rem_next;
        dsr_reg       <= dsr_next;
        quo_reg       <= quo_next;
        bin_reg       <= bin_next;
        bin_index_reg <= bin_index_next;
        bin_count_reg <= bin_count_next;
        interval_reg  <= interval_next;
        first_reg     <= first_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            count_mem[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= count_mem[mem_addr];
    end

    assign busy         = (state_reg != ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign done         = done_reg;
    assign bin_index    = bin_index_reg;
    assign bin_count    = bin_count_reg;
    assign interval_ns  = interval_reg;
    assign first_sample = first_reg;

`ifndef ASSERT_OFF
    a_first_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_RECORD) && !have_prev_reg) |=> (done && first_sample))
        else $error("first timestamp did not give a priming result");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a command is still in progress");

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> (rem_reg < (dsr_reg << 1)))
        else $error("divider remainder out of range for one quotient bit");
`endif

endmodule : interval_histogram_core
`default_nettype wire

FILE: verif/tb_interval_histogram_core.sv
// ----------------------------------------------------------------------------
// Interval histogram core testbench
// Sends timestamp records and bin reads through the start/busy command port,
// rewrites the bin bounds between phases, and checks every done strobe
// against a bit-exact histogram predictor held in the testbench.
// ----------------------------------------------------------------------------
module tb_interval_histogram_core;
    import ih_pkg::*;

    localparam int     NBINS        = NUM_BINS_DEF;
    localparam longint NS_PER_SEC   = 64'sd1000000000;
    localparam longint LATEST_STAMP = 64'sd4294967295 * NS_PER_SEC + 64'sd999999999;

    typedef struct packed {
        logic [6:0]  bin;
        logic [31:0] count;
        logic [31:0] gap;
        logic        first;
    } bin_update_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 op;
    logic [31:0]          stamp_seconds;
    logic [29:0]          stamp_nanoseconds;
    logic [6:0]           read_bin;
    logic                 done;
    logic [6:0]           bin_index;
    logic [31:0]          bin_count;
    logic [31:0]          interval_ns;
    logic                 first_sample;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    // Predictor state, kept in step with the block at each transfer.
    logic [31:0] lower_ns;
    logic [31:0] upper_ns;
    logic [31:0] prev_sec;
    logic [29:0] prev_nsec;
    logic        primed;
    logic [31:0] bin_tally [NBINS];

    bin_update_t due_updates [$];
    bin_update_t want;
    longint      last_stamp;
    int          fail_count;
    int          n_records;
    int          n_reads;
    int          n_settings;

    interval_histogram_core i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .op                (op),
        .stamp_seconds     (stamp_seconds),
        .stamp_nanoseconds (stamp_nanoseconds),
        .read_bin          (read_bin),
        .done              (done),
        .bin_index         (bin_index),
        .bin_count         (bin_count),
        .interval_ns       (interval_ns),
        .first_sample      (first_sample),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] gap_between(input logic [31:0] s, input logic [29:0] ns,
                                                input logic [31:0] ps, input logic [29:0] pns);
        longint diff_ns;
        diff_ns = (longint'({32'd0, s}) - longint'({32'd0, ps})) * NS_PER_SEC
                + (longint'({34'd0, ns}) - longint'({34'd0, pns}));
        if (diff_ns < 0)
            diff_ns = -diff_ns;
        return (diff_ns > 64'sd4294967295) ? 32'hFFFF_FFFF : diff_ns[31:0];
    endfunction

    function automatic logic [6:0] bin_for_gap(input logic [31:0] gap);
        longint q;
        if (upper_ns <= lower_ns || gap < lower_ns)
            return '0;
        q = (longint'({32'd0, gap - lower_ns}) * NBINS)
          / (longint'({32'd0, upper_ns}) - longint'({32'd0, lower_ns}));
        if (q >= NBINS)
            q = NBINS - 1;
        return q[6:0];
    endfunction

    // Applies one command to the predicted histogram and returns its result.
    function automatic bin_update_t histogram_update(input logic o, input logic [31:0] s,
                                                     input logic [29:0] ns,
                                                     input logic [6:0] rb);
        bin_update_t r;
        logic [6:0]  b;
        r = '0;
        if (o == OP_READ)
        begin
            r.bin   = rb;
            r.count = bin_tally[rb];
        end
        else if (!primed)
        begin
            primed    = 1'b1;
            prev_sec  = s;
            prev_nsec = ns;
            r.first   = 1'b1;
        end
        else
        begin
            r.gap = gap_between(s, ns, prev_sec, prev_nsec);
            b     = bin_for_gap(r.gap);
            if (bin_tally[b] != 32'hFFFF_FFFF)
                bin_tally[b] = bin_tally[b] + 32'd1;
            prev_sec  = s;
            prev_nsec = ns;
            r.bin     = b;
            r.count   = bin_tally[b];
        end
        return r;
    endfunction

    function automatic longint rand_below(input longint n);
        bit [63:0] r;
        r = {$urandom, $urandom};
        return longint'(r % 64'(n));
    endfunction

    // Start is left high after the transfer so that a following call in the
    // same time step gives back-to-back commands; pause or wait_drained drops it.
    task automatic send_item(input logic o, input logic [31:0] s, input logic [29:0] ns,
                             input logic [6:0] rb);
        bin_update_t upd;
        start             <= 1'b1;
        op                <= o;
        stamp_seconds     <= s;
        stamp_nanoseconds <= ns;
        read_bin          <= rb;
        do @(posedge clk); while (busy);
        upd         = histogram_update(o, s, ns, rb);
        due_updates = {due_updates, upd};
        if (o == OP_READ)
            n_reads++;
        else
            n_records++;
    endtask

    task automatic pause(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge clk); while (due_updates.size() != 0 || busy);
    endtask

    task automatic write_bounds(input logic [31:0] lo, input logic [31:0] hi);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_LOWER_BOUND;
        cfg_data  <= lo;
        do @(posedge clk); while (!cfg_ready);
        lower_ns = lo;
        cfg_index <= CFG_UPPER_BOUND;
        cfg_data  <= hi;
        do @(posedge clk); while (!cfg_ready);
        upper_ns = hi;
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic record_stamp(input logic [31:0] s, input logic [29:0] ns);
        last_stamp = longint'({32'd0, s}) * NS_PER_SEC + longint'({34'd0, ns});
        send_item(OP_RECORD, s, ns, 7'($urandom));
    endtask

    // A negative step gives a timestamp earlier than the previous one unless it would fall below zero.
    task automatic record_gap(input longint step);
        longint t;
        t = last_stamp + step;
        if (t < 0 || t > LATEST_STAMP)
            t = last_stamp - step;
        record_stamp(32'(t / NS_PER_SEC), 30'(t % NS_PER_SEC));
    endtask

    task automatic read_bin_count(input logic [6:0] rb);
        send_item(OP_READ, $urandom, 30'($urandom), rb);
    endtask

    task automatic record_random();
        longint lo;
        longint hi;
        longint step;
        int     pick;
        lo = longint'({32'd0, lower_ns});
        hi = longint'({32'd0, upper_ns});
        if (hi <= lo)
            hi = lo + 64'sd2000000;
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            record_stamp($urandom, 30'($urandom));
            return;
        end
        if (pick < 55)
            step = lo + rand_below(hi - lo + 1);
        else if (pick < 65)
            step = lo - rand_below(1001);
        else if (pick < 75)
            step = hi + rand_below(1001);
        else if (pick < 85)
            step = rand_below(4);
        else
            step = rand_below(1000) * NS_PER_SEC + rand_below(NS_PER_SEC);
        if ($urandom_range(0, 4) == 0)
            step = -step;
        record_gap(step);
    endtask

    task automatic test_first_sample();
        read_bin_count(7'd0);
        record_stamp(32'd0, 30'd0);
        read_bin_count(7'd127);
        wait_drained();
    endtask

    task automatic test_default_edges();
        record_gap(64'sd499999);
        record_gap(64'sd500000);
        record_gap(64'sd6999999);
        record_gap(64'sd7000000);
        record_gap(64'sd3750000);
        record_gap(-64'sd2000000);
        record_gap(64'sd0);
        read_bin_count(7'd127);
        wait_drained();
    endtask

    task automatic test_wide_stamps();
        // Nanosecond part beyond one second, and a jump that saturates the gap.
        record_stamp(32'hFFFF_FFFF, 30'h3FFF_FFFF);
        record_stamp(32'hFFFF_FFFF, 30'd0);
        record_stamp(32'd0, 30'd0);
        record_gap(64'sd4294967295);
        record_gap(64'sd4294967296);
        read_bin_count(7'd0);
        wait_drained();
    endtask

    task automatic test_bound_extremes();
        write_bounds(32'd0, 32'hFFFF_FFFF);
        record_gap(64'sd4294967294);
        record_gap(64'sd33554431);
        wait_drained();
        // Empty range: equal bounds, then upper below lower.
        write_bounds(32'd1000, 32'd1000);
        record_gap(64'sd5000);
        wait_drained();
        write_bounds(32'hFFFF_FFFF, 32'd0);
        record_gap(64'sd123456789);
        wait_drained();
        write_bounds(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        record_gap(64'sd4294967295);
        record_gap(64'sd4294967294);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int          burst;
        logic [31:0] lo;
        for (int phase = 0; phase < 6; phase++)
        begin
            wait_drained();
            case (phase)
                0: write_bounds(LOWER_BOUND_RST, UPPER_BOUND_RST);
                1:
                begin
                    lo = $urandom_range(0, 1000);
                    write_bounds(lo, lo + $urandom_range(128, 20000));
                end
                2: write_bounds($urandom, $urandom);
                3: write_bounds(32'd0, 32'hFFFF_FFFF);
                4:
                begin
                    lo = $urandom_range(0, 5000000);
                    write_bounds(lo, $urandom_range(0, lo));
                end
                default: write_bounds(32'hFFFF_F000, 32'hFFFF_FFFF);
            endcase
            burst = $urandom_range(1, 16);
            for (int i = 0; i < 145; i++)
            begin
                if ($urandom_range(0, 4) == 0)
                    read_bin_count(7'($urandom));
                else
                    record_random();
                burst--;
                // Phase three runs with no pauses between transfers, apart from one drain midway through.
                if (i == 72)
                    wait_drained();
                else if (burst == 0 && phase != 3)
                    pause($urandom_range(1, 25));
                if (burst == 0)
                    burst = $urandom_range(1, 16);
            end
        end
        wait_drained();
    endtask

    task automatic test_readback();
        for (int b = 0; b < NBINS; b++)
            read_bin_count(7'(b));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (due_updates.size() == 0)
            begin
                $error("result with nothing pending: bin_index %0d bin_count %0d",
                       bin_index, bin_count);
                fail_count++;
            end
            else
            begin
                want = due_updates.pop_front();
                if (bin_index !== want.bin)
                begin
                    $error("bin_index: expected %0d, got %0d", want.bin, bin_index);
                    fail_count++;
                end
                if (bin_count !== want.count)
                begin
                    $error("bin_count: expected %0d, got %0d", want.count, bin_count);
                    fail_count++;
                end
                if (interval_ns !== want.gap)
                begin
                    $error("interval_ns: expected %0d, got %0d", want.gap, interval_ns);
                    fail_count++;
                end
                if (first_sample !== want.first)
                begin
                    $error("first_sample: expected %0d, got %0d", want.first, first_sample);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #5000000;
        $display("Timed out with %0d results still pending.", due_updates.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        lower_ns   = LOWER_BOUND_RST;
        upper_ns   = UPPER_BOUND_RST;
        prev_sec   = '0;
        prev_nsec  = '0;
        primed     = 1'b0;
        last_stamp = 0;
        fail_count = 0;
        n_records  = 0;
        n_reads    = 0;
        n_settings = 1;
        foreach (bin_tally[i])
            bin_tally[i] = '0;

        rst_n             <= 1'b0;
        start             <= 1'b0;
        op                <= OP_RECORD;
        stamp_seconds     <= '0;
        stamp_nanoseconds <= '0;
        read_bin          <= '0;
        cfg_valid         <= 1'b0;
        cfg_index         <= CFG_LOWER_BOUND;
        cfg_data          <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_first_sample();
        test_default_edges();
        test_wide_stamps();
        test_bound_extremes();
        test_random_traffic();
        test_readback();

        start <= 1'b0;
        for (int k = 0; k < 2000 && (due_updates.size() != 0 || busy); k++)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (due_updates.size() != 0)
        begin
            $error("%0d expected results never arrived", due_updates.size());
            fail_count++;
        end

        $display("Checked %0d timestamp records and %0d bin reads over %0d bound settings,",
                 n_records, n_reads, n_settings);
        $display("with bin edges, saturated gaps, empty ranges and a full histogram readback.");
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule : tb_interval_histogram_core

FILE: sim.f
design/ih_pkg.sv
design/interval_histogram_core.sv
verif/tb_interval_histogram_core.sv
